// ----- rtl/core/stbs_pkg.sv -----
// ----------------------------------------------------------------------------
// stbs_pkg
// Shared types and constants for the sorted-table binary search block.
// ----------------------------------------------------------------------------
`default_nettype none

package stbs_pkg;

    localparam int DEPTH_DEFAULT = 16;

    localparam int CNT_W      = 5;
    localparam int INDEX_W    = 4;
    localparam int WORD_W     = 32;
    localparam int PROBE_W    = 3;
    localparam int S_TDATA_W  = 40;
    localparam int M_TDATA_W  = 8;

    localparam int INDEX_LSB  = 0;
    localparam int WORD_LSB   = INDEX_LSB + INDEX_W;
    localparam int FOUND_LSB  = 0;
    localparam int PROBE_LSB  = 1;

    localparam logic [CNT_W-1:0]   COUNT_RESET = 5'd16;
    localparam logic [PROBE_W-1:0] PROBE_MAX   = 3'd7;

    typedef enum logic {
        REQ_WRITE  = 1'b0,
        REQ_SEARCH = 1'b1
    } req_t;

    typedef enum logic {
        ST_IDLE,
        ST_PROBE
    } ctrl_state_t;

    typedef struct packed {
        logic wr;
        logic start;
        logic step;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic done;
    } status_t;

endpackage

`default_nettype wire

// ----- rtl/core/stbs_ram.sv -----
// ----------------------------------------------------------------------------
// stbs_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module stbs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] ram_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            ram_reg[waddr] <= wdata;
        end
        rdata_reg <= ram_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- rtl/core/stbs_datapath.sv -----
// ----------------------------------------------------------------------------
// stbs_datapath
// Holds the entry count, the search range, the key, the probe counter and the
// result register, and drives the table RAM.
// ----------------------------------------------------------------------------
`default_nettype none

module stbs_datapath
    import stbs_pkg::*;
#(
    parameter int TABLE_DEPTH = DEPTH_DEFAULT
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_we,
    input  wire logic [CNT_W-1:0]     cfg_wdata,
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    input  wire cmd_t                 cmd,
    output status_t                   status,
    output logic      [M_TDATA_W-1:0] m_tdata
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int NW = (AW + 1 > CNT_W) ? AW + 1 : CNT_W;
    localparam logic [NW-1:0] DEPTH_N = NW'(TABLE_DEPTH);
    localparam logic [NW-1:0] ONE_N   = NW'(1);

    logic [CNT_W-1:0]         count_reg;
    logic [AW-1:0]            lo_reg, hi_reg;
    logic signed [WORD_W-1:0] key_reg;
    logic [PROBE_W-1:0]       probes_reg;
    logic                     found_reg;
    logic [PROBE_W-1:0]       probe_out_reg;

    logic [INDEX_W-1:0]       in_index;
    logic signed [WORD_W-1:0] in_word;
    logic [NW-1:0]            idx_ext;
    logic                     idx_ok;
    logic [NW-1:0]            n_raw, n_use, n_m1;
    logic [AW-1:0]            hi_init;
    logic [AW:0]              sum_cur, sum_next;
    logic [AW-1:0]            mid;
    logic [AW-1:0]            lo_next, hi_next;
    logic [AW-1:0]            raddr;
    logic signed [WORD_W-1:0] rdata;
    logic [PROBE_W-1:0]       probes_cur;
    logic                     key_eq, key_lt, key_gt;
    logic                     go_left, go_right, done, hit;

    assign in_index = s_tdata[WORD_LSB-1:INDEX_LSB];
    assign in_word  = s_tdata[WORD_LSB+WORD_W-1:WORD_LSB];
    assign idx_ext  = NW'(in_index);
    assign idx_ok   = idx_ext < DEPTH_N;

    always_comb begin
        n_raw = NW'(count_reg);
        if (n_raw == '0) begin
            n_use = ONE_N;
        end else if (n_raw > DEPTH_N) begin
            n_use = DEPTH_N;
        end else begin
            n_use = n_raw;
        end
        n_m1    = n_use - ONE_N;
        hi_init = n_m1[AW-1:0];
    end

    always_comb begin
        sum_cur    = {1'b0, lo_reg} + {1'b0, hi_reg};
        mid        = sum_cur[AW:1];
        key_eq     = key_reg == rdata;
        key_lt     = key_reg < rdata;
        key_gt     = rdata < key_reg;
        probes_cur = (probes_reg == PROBE_MAX) ? probes_reg : probes_reg + 3'd1;
        go_left    = 1'b0;
        go_right   = 1'b0;
        done       = 1'b0;
        hit        = 1'b0;
        if (lo_reg == hi_reg) begin
            done = 1'b1;
            hit  = key_eq;
        end else if (key_eq) begin
            done = 1'b1;
            hit  = 1'b1;
        end else if (key_lt && (mid > lo_reg)) begin
            go_left = 1'b1;
        end else if (key_gt && (mid < hi_reg)) begin
            go_right = 1'b1;
        end else begin
            done = 1'b1;
        end
    end

    always_comb begin
        lo_next = lo_reg;
        hi_next = hi_reg;
        if (cmd.start) begin
            lo_next = '0;
            hi_next = hi_init;
        end else if (cmd.step) begin
            if (go_left) begin
                hi_next = mid - AW'(1);
            end
            if (go_right) begin
                lo_next = mid + AW'(1);
            end
        end
        sum_next = {1'b0, lo_next} + {1'b0, hi_next};
        raddr    = sum_next[AW:1];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= COUNT_RESET;
        end else if (cfg_we) begin
            count_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        lo_reg <= lo_next;
        hi_reg <= hi_next;
        if (cmd.start) begin
            key_reg    <= in_word;
            probes_reg <= '0;
        end else if (cmd.step) begin
            probes_reg <= probes_cur;
        end
        if (cmd.emit) begin
            found_reg     <= hit;
            probe_out_reg <= probes_cur;
        end
    end

    stbs_ram #(
        .WIDTH (WORD_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (cmd.wr && idx_ok),
        .waddr (idx_ext[AW-1:0]),
        .wdata (in_word),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign status.done = done;
    assign m_tdata     = {{(M_TDATA_W-PROBE_W-1){1'b0}}, probe_out_reg, found_reg};

endmodule

`default_nettype wire

// ----- rtl/core/stbs_ctrl.sv -----
// ----------------------------------------------------------------------------
// stbs_ctrl
// Sequencer for the search: accepts items, steps the probes and owns the
// result valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module stbs_ctrl
    import stbs_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    s_tvalid,
    output logic         s_tready,
    input  wire logic    s_tuser,
    output logic         m_tvalid,
    input  wire logic    m_tready,
    input  wire status_t status,
    output cmd_t         cmd
);

    ctrl_state_t state_reg, state_next;
    logic        m_tvalid_reg, m_tvalid_next;
    logic        out_busy;

    assign out_busy = m_tvalid_reg && !m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        cmd           = '0;
        s_tready      = 1'b0;
        m_tvalid_next = m_tready ? 1'b0 : m_tvalid_reg;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    if (req_t'(s_tuser) == REQ_SEARCH) begin
                        cmd.start  = 1'b1;
                        state_next = ST_PROBE;
                    end else begin
                        cmd.wr = 1'b1;
                    end
                end
            end
            ST_PROBE: begin
                if (!status.done) begin
                    cmd.step = 1'b1;
                end else if (!out_busy) begin
                    cmd.emit      = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;

endmodule

`default_nettype wire

// ----- rtl/core/sorted_table_binary_search.sv -----
// ----------------------------------------------------------------------------
// sorted_table_binary_search
// Table of signed words loaded by write items and searched by binary search.
// ----------------------------------------------------------------------------
// Channel   Direction  Content
// cfg       in         entry_count
// s_        in         tuser: req_type; tdata: entry_index, data_word
// m_        out        tdata: found, probe_count
//
// A write item goes into the table as it is accepted. For a search item, the
// accepting cycle issues the first read, as the table RAM has one registered
// read port, and the probes then follow one another while the input is held
// off. Reset clears the control state and sets entry_count to 16; table
// contents are undefined until written.
// The last probe waits while the previous result has not been taken.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_table_binary_search
    import stbs_pkg::*;
#(
    parameter int TABLE_DEPTH = DEPTH_DEFAULT
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_we,
    input  wire logic [CNT_W-1:0]     cfg_wdata,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,   // entry_index, data_word
    input  wire logic                 s_tuser,   // req_type
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic      [M_TDATA_W-1:0] m_tdata    // found, probe_count
);

    cmd_t    cmd;
    status_t status;

    stbs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    stbs_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .cmd       (cmd),
        .status    (status),
        .m_tdata   (m_tdata)
    );

endmodule

`default_nettype wire

// ----- rtl/core/stbs_checker.sv -----
// ----------------------------------------------------------------------------
// stbs_checker
// Port-level checks for the sorted-table binary search block.
// ----------------------------------------------------------------------------
`default_nettype none

module stbs_checker
    import stbs_pkg::*;
(
    input wire logic                 aclk,
    input wire logic                 aresetn,
    input wire logic                 s_tvalid,
    input wire logic                 s_tready,
    input wire logic                 s_tuser,
    input wire logic                 m_tvalid,
    input wire logic                 m_tready,
    input wire logic [M_TDATA_W-1:0] m_tdata
);

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("Result item changed while stalled.");

    a_probe_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[PROBE_LSB+PROBE_W-1:PROBE_LSB] != '0)
        else $error("Result item reports no probes.");

    a_search_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser |=> !s_tready)
        else $error("Item accepted during a search.");

    a_write_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !s_tuser && !m_tvalid |=> !m_tvalid)
        else $error("Write item produced a result.");

endmodule

bind sorted_table_binary_search stbs_checker u_stbs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

// ----- tb/tb_sorted_table_binary_search.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sorted_table_binary_search
// Self-checking testbench for the sorted-table binary search block.
// A short table of directed items loads the table, searches it at its ends
// and at its midpoint, and covers counts of zero and above the table depth,
// and an unsorted entry. Random phases follow; each sets the entry count,
// reloads the table, mostly in ascending order, or rewrites a few entries, and
// sends searches keyed mostly from the table. A local predictor supplies each
// expected result that no directed item gives. Both channels idle at random,
// and twice the result side holds off long enough for the input side to stall.
// ----------------------------------------------------------------------------

module tb_sorted_table_binary_search;
    import stbs_pkg::*;

    localparam int DEPTH      = DEPTH_DEFAULT;
    localparam int ITEM_GOAL  = 850;
    localparam int SETTLE     = 12;
    localparam int HOLD_OFF   = 300;
    localparam int CYCLE_CAP  = 600000;

    typedef enum logic [1:0] {
        ROW_WRITE,
        ROW_SEARCH,
        ROW_COUNT
    } row_kind_t;

    typedef struct packed {
        logic               found;
        logic [PROBE_W-1:0] probes;
    } verdict_t;

    typedef struct {
        row_kind_t          kind;
        logic [INDEX_W-1:0] idx;
        logic [WORD_W-1:0]  word;
        bit                 typed;
        verdict_t           want;
    } step_row_t;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 cfg_we;
    logic [CNT_W-1:0]     cfg_wdata;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;

    logic [WORD_W-1:0] tbl_model [DEPTH];
    logic [CNT_W-1:0]  cnt_model = COUNT_RESET;
    verdict_t          verdict_q [$];
    step_row_t         plan [$];
    int                errors = 0;
    int                items_sent = 0;
    bit                steady_feed = 1'b0;
    bit                squeeze_req = 1'b0;

    sorted_table_binary_search #(
        .TABLE_DEPTH(DEPTH)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #6 aclk = ~aclk;

    function automatic int pause_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            return $urandom_range(1, 3);
        end else if (r < 93) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic int live_entries();
        int n;
        n = int'(cnt_model);
        if (n == 0) begin
            n = 1;
        end
        if (n > DEPTH) begin
            n = DEPTH;
        end
        return n;
    endfunction

    function automatic verdict_t search_table(input logic [WORD_W-1:0] key);
        int       lo;
        int       hi;
        int       mid;
        bit       done;
        verdict_t v;
        lo = 0;
        hi = live_entries() - 1;
        done = 1'b0;
        v.found = 1'b0;
        v.probes = '0;
        while (!done) begin
            if (v.probes != PROBE_MAX) begin
                v.probes = v.probes + 3'd1;
            end
            if (lo == hi) begin
                v.found = (key == tbl_model[lo]);
                done = 1'b1;
            end else begin
                mid = (lo + hi) / 2;
                if (key == tbl_model[mid]) begin
                    v.found = 1'b1;
                    done = 1'b1;
                end else if ($signed(key) < $signed(tbl_model[mid]) && mid > lo) begin
                    hi = mid - 1;
                end else if ($signed(tbl_model[mid]) < $signed(key) && mid < hi) begin
                    lo = mid + 1;
                end else begin
                    done = 1'b1;
                end
            end
        end
        return v;
    endfunction

    function automatic logic [WORD_W-1:0] pick_key();
        int                r;
        logic [WORD_W-1:0] w;
        w = tbl_model[$urandom_range(0, live_entries() - 1)];
        r = $urandom_range(0, 99);
        if (r < 50) begin
            return w;
        end else if (r < 65) begin
            return w + 32'd1;
        end else if (r < 75) begin
            return w - 32'd1;
        end else if (r < 90) begin
            return $urandom;
        end else if (r < 95) begin
            return 32'h8000_0000;
        end
        return 32'h7FFF_FFFF;
    endfunction

    function automatic step_row_t mk_row(input row_kind_t kind, input logic [INDEX_W-1:0] idx,
                                         input logic [WORD_W-1:0] word, input bit typed,
                                         input logic found, input logic [PROBE_W-1:0] probes);
        step_row_t row;
        row.kind = kind;
        row.idx = idx;
        row.word = word;
        row.typed = typed;
        row.want.found = found;
        row.want.probes = probes;
        return row;
    endfunction

    task automatic offer(input req_t kind, input logic [INDEX_W-1:0] idx,
                         input logic [WORD_W-1:0] word, input bit typed, input verdict_t want);
        logic [S_TDATA_W-1:0] pk;
        int                   gap;
        gap = (steady_feed || $urandom_range(0, 99) < 55) ? 0 : pause_len();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        pk = '0;
        pk[INDEX_LSB +: INDEX_W] = idx;
        pk[WORD_LSB +: WORD_W] = word;
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= pk;
        do @(posedge aclk); while (s_tready !== 1'b1);
        if (kind == REQ_WRITE) begin
            tbl_model[idx] = word;
        end else begin
            verdict_q.push_back(typed ? want : search_table(word));
        end
        items_sent++;
    endtask

    task automatic set_count(input logic [CNT_W-1:0] c);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (verdict_q.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= c;
        @(posedge aclk);
        cfg_we <= 1'b0;
        cnt_model = c;
    endtask

    // Result side: random stalls, runs of readiness, and the long hold-offs.
    initial begin : result_side
        int       stall_left;
        int       run_left;
        int       hold_left;
        int       r;
        verdict_t got;
        verdict_t want;
        stall_left = 0;
        run_left = 0;
        hold_left = 0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (m_tvalid === 1'b1 && m_tready === 1'b1) begin
                got.found = m_tdata[FOUND_LSB];
                got.probes = m_tdata[PROBE_LSB +: PROBE_W];
                if (verdict_q.size() == 0) begin
                    $display("%0t: unexpected result item: found=%0b probes=%0d",
                             $time, got.found, got.probes);
                    errors++;
                end else begin
                    want = verdict_q.pop_front();
                    if (got.found !== want.found) begin
                        $display("%0t: found mismatch: expected %0b, actual %0b",
                                 $time, want.found, got.found);
                        errors++;
                    end
                    if (got.probes !== want.probes) begin
                        $display("%0t: probe_count mismatch: expected %0d, actual %0d",
                                 $time, want.probes, got.probes);
                        errors++;
                    end
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (squeeze_req) begin
                squeeze_req = 1'b0;
                hold_left = HOLD_OFF;
                m_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (run_left > 0) begin
                run_left--;
                m_tready <= 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 15) begin
                    run_left = $urandom_range(20, 60);
                end else if (r < 45) begin
                    stall_left = pause_len() - 1;
                end
                m_tready <= !(r >= 15 && r < 45);
            end
        end
    end

    initial begin : watchdog
        repeat (CYCLE_CAP) @(posedge aclk);
        $display("tb_sorted_table_binary_search: done, errors");
        $finish;
    end

    initial begin : stimulus
        logic [WORD_W-1:0] vals [DEPTH];
        longint            acc;
        int                e;
        int                off;
        int                stride;
        int                k;
        int                r;
        int                phase;
        int                n_search;
        logic [CNT_W-1:0]  c;

        aresetn <= 1'b0;
        cfg_we <= 1'b0;
        cfg_wdata <= '0;
        s_tvalid <= 1'b0;
        s_tuser <= REQ_WRITE;
        s_tdata <= '0;
        for (int i = 0; i < DEPTH; i++) begin
            tbl_model[i] = '0;
        end

        // Table runs from the most negative word to the most positive one.
        plan.push_back(mk_row(ROW_WRITE, 4'd0, 32'h8000_0000, 1'b0, 1'b0, 3'd0));
        for (int i = 1; i < DEPTH - 1; i++) begin
            plan.push_back(mk_row(ROW_WRITE, INDEX_W'(i), WORD_W'((i - 8) * 1000),
                                  1'b0, 1'b0, 3'd0));
        end
        plan.push_back(mk_row(ROW_WRITE, 4'd15, 32'h7FFF_FFFF, 1'b0, 1'b0, 3'd0));
        plan.push_back(mk_row(ROW_SEARCH, 4'd0, -32'sd1000, 1'b1, 1'b1, 3'd1));
        plan.push_back(mk_row(ROW_SEARCH, 4'd15, 32'h8000_0000, 1'b1, 1'b1, 3'd4));
        plan.push_back(mk_row(ROW_SEARCH, 4'd5, 32'h7FFF_FFFF, 1'b1, 1'b1, 3'd5));
        plan.push_back(mk_row(ROW_SEARCH, 4'd9, 32'd2500, 1'b0, 1'b0, 3'd0));
        plan.push_back(mk_row(ROW_COUNT, 4'd0, 32'd0, 1'b0, 1'b0, 3'd0));
        plan.push_back(mk_row(ROW_SEARCH, 4'd0, 32'h8000_0000, 1'b1, 1'b1, 3'd1));
        plan.push_back(mk_row(ROW_SEARCH, 4'd0, 32'd0, 1'b1, 1'b0, 3'd1));
        plan.push_back(mk_row(ROW_COUNT, 4'd0, 32'd31, 1'b0, 1'b0, 3'd0));
        plan.push_back(mk_row(ROW_SEARCH, 4'd0, 32'h7FFF_FFFF, 1'b1, 1'b1, 3'd5));
        plan.push_back(mk_row(ROW_WRITE, 4'd7, 32'h7FFF_FFFF, 1'b0, 1'b0, 3'd0));
        plan.push_back(mk_row(ROW_SEARCH, 4'd0, 32'h7FFF_FFFF, 1'b0, 1'b0, 3'd0));
        plan.push_back(mk_row(ROW_SEARCH, 4'd0, 32'd6000, 1'b0, 1'b0, 3'd0));

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        foreach (plan[i]) begin
            case (plan[i].kind)
                ROW_COUNT: begin
                    set_count(plan[i].word[CNT_W-1:0]);
                end
                ROW_WRITE: begin
                    offer(REQ_WRITE, plan[i].idx, plan[i].word, 1'b0, plan[i].want);
                end
                default: begin
                    offer(REQ_SEARCH, plan[i].idx, plan[i].word, plan[i].typed, plan[i].want);
                end
            endcase
        end

        phase = 0;
        while (items_sent < ITEM_GOAL) begin
            r = $urandom_range(0, 9);
            case (r)
                0: c = 5'd1;
                1: c = 5'd16;
                2: c = 5'd0;
                3: c = CNT_W'($urandom_range(17, 31));
                default: c = CNT_W'($urandom_range(2, 15));
            endcase
            set_count(c);
            steady_feed = ($urandom_range(0, 3) == 0);

            r = $urandom_range(0, 9);
            if (r < 9) begin
                if (r < 7) begin
                    acc = ($urandom_range(0, 4) == 0) ? -64'sd2147483648
                                                      : longint'($signed($urandom));
                    e = $urandom_range(0, 30);
                    for (int i = 0; i < DEPTH; i++) begin
                        if (acc > 64'sd2147483647) begin
                            acc = 64'sd2147483647;
                        end
                        vals[i] = acc[WORD_W-1:0];
                        acc = acc + longint'($urandom_range(0, 32'd1 << e));
                    end
                end else begin
                    for (int i = 0; i < DEPTH; i++) begin
                        vals[i] = $urandom;
                    end
                end
                off = $urandom_range(0, DEPTH - 1);
                stride = 2 * $urandom_range(0, 7) + 1;
                for (int i = 0; i < DEPTH; i++) begin
                    k = (off + i * stride) % DEPTH;
                    offer(REQ_WRITE, INDEX_W'(k), vals[k], 1'b0, '0);
                end
            end else begin
                repeat ($urandom_range(1, 4)) begin
                    offer(REQ_WRITE, INDEX_W'($urandom), $urandom, 1'b0, '0);
                end
            end

            if (phase == 3 || phase == 12) begin
                squeeze_req = 1'b1;
                steady_feed = 1'b1;
            end
            n_search = $urandom_range(10, 40);
            repeat (n_search) begin
                if ($urandom_range(0, 19) == 0) begin
                    offer(REQ_WRITE, INDEX_W'($urandom), $urandom, 1'b0, '0);
                end else begin
                    offer(REQ_SEARCH, INDEX_W'($urandom), pick_key(), 1'b0, '0);
                end
            end
            phase++;
        end

        s_tvalid <= 1'b0;
        while (verdict_q.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (errors == 0) begin
            $display("tb_sorted_table_binary_search: done, clean");
        end else begin
            $display("tb_sorted_table_binary_search: done, errors");
        end
        $finish;
    end

endmodule
